// File: rtl/core/ppp_pkg.sv
package ppp_pkg;

    localparam int IMG_WIDTH_DEF  = 640;
    localparam int IMG_HEIGHT_DEF = 480;

    // datapath widths
    localparam int RW    = 28;   // rotation coefficient, Q20
    localparam int RELW  = 33;   // point minus camera position
    localparam int PRODW = 61;   // coefficient times offset
    localparam int SUMW  = 64;
    localparam int CAMW  = 44;   // camera coordinate before range check
    localparam int FARW  = 36;   // far plane, Q18
    localparam int DENW  = 40;
    localparam int DIV_W = 56;
    localparam int DIV_Q = 16;

    localparam logic signed [35:0] Q28_ONE  = 36'sd268435456;
    localparam logic signed [36:0] NEAR_ONE = 37'sd65536;
    localparam logic [FARW-1:0]    FAR_DEF  = FARW'(5 * 262144);
    localparam logic [FARW-1:0]    FAR_MIN  = FARW'(13369);
    localparam logic [16:0]        NORM_ONE = 17'd32768;
    localparam logic [16:0]        DF_MIN   = 17'd3277;

    typedef enum logic [2:0] {
        REG_CAM_X  = 3'd0,
        REG_CAM_Y  = 3'd1,
        REG_CAM_Z  = 3'd2,
        REG_QUAT_W = 3'd3,
        REG_QUAT_X = 3'd4,
        REG_QUAT_Y = 3'd5,
        REG_QUAT_Z = 3'd6,
        REG_MAX_RANGE = 3'd7
    } reg_idx_t;

    typedef logic [RW-1:0] rcoef_t;

    typedef struct packed {
        rcoef_t [8:0]      r;       // r[row*3+col]
        logic              zero_q;
        logic [FARW-1:0]   far18;
        logic [DENW-1:0]   den;
        logic [31:0]       cpx;
        logic [31:0]       cpy;
        logic [31:0]       cpz;
    } cfg_t;

endpackage

// File: rtl/core/ppp_cfg.sv
module ppp_cfg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    output ppp_pkg::cfg_t     cfg_o
);

    logic signed [31:0] cam_x_reg, cam_y_reg, cam_z_reg, max_range_reg;
    logic signed [15:0] qw_reg, qx_reg, qy_reg, qz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cam_x_reg     <= '0;
            cam_y_reg     <= '0;
            cam_z_reg     <= '0;
            qw_reg        <= 16'sd16384;
            qx_reg        <= '0;
            qy_reg        <= '0;
            qz_reg        <= '0;
            max_range_reg <= '0;
        end else if (cfg_valid) begin
            unique case (ppp_pkg::reg_idx_t'(cfg_index))
                ppp_pkg::REG_CAM_X:     cam_x_reg     <= cfg_data;
                ppp_pkg::REG_CAM_Y:     cam_y_reg     <= cfg_data;
                ppp_pkg::REG_CAM_Z:     cam_z_reg     <= cfg_data;
                ppp_pkg::REG_QUAT_W:    qw_reg        <= cfg_data[15:0];
                ppp_pkg::REG_QUAT_X:    qx_reg        <= cfg_data[15:0];
                ppp_pkg::REG_QUAT_Y:    qy_reg        <= cfg_data[15:0];
                ppp_pkg::REG_QUAT_Z:    qz_reg        <= cfg_data[15:0];
                ppp_pkg::REG_MAX_RANGE: max_range_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage A: quaternion products, zero-quaternion flag and clamped far plane
    logic signed [31:0] xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg;
    logic signed [31:0] wx_reg, wy_reg, wz_reg;
    logic               zero_a_reg;
    logic signed [35:0] far_a_next;
    logic [ppp_pkg::FARW-1:0] far_a_reg;

    always_comb begin
        if (max_range_reg > 32'sd0) begin
            far_a_next = 36'(max_range_reg) * 36'sd5;
        end else begin
            far_a_next = 36'(ppp_pkg::FAR_DEF);
        end
    end

    always_ff @(posedge aclk) begin
        xx_reg     <= qx_reg * qx_reg;
        yy_reg     <= qy_reg * qy_reg;
        zz_reg     <= qz_reg * qz_reg;
        xy_reg     <= qx_reg * qy_reg;
        xz_reg     <= qx_reg * qz_reg;
        yz_reg     <= qy_reg * qz_reg;
        wx_reg     <= qw_reg * qx_reg;
        wy_reg     <= qw_reg * qy_reg;
        wz_reg     <= qw_reg * qz_reg;
        zero_a_reg <= (qw_reg == '0) && (qx_reg == '0) && (qy_reg == '0) && (qz_reg == '0);
        far_a_reg  <= (far_a_next < 36'(ppp_pkg::FAR_MIN)) ? ppp_pkg::FAR_MIN
                                                           : ppp_pkg::FARW'(far_a_next);
    end

    // stage B: matrix rounded to Q20, depth ratio denominator
    logic signed [35:0] raw [9];
    logic signed [35:0] rsum [9];
    ppp_pkg::rcoef_t    r_next [9];
    ppp_pkg::rcoef_t    r_reg [9];
    logic               zero_b_reg;
    logic [ppp_pkg::FARW-1:0] far_b_reg;
    logic [ppp_pkg::DENW-1:0] den_reg;

    always_comb begin
        raw[0] = ppp_pkg::Q28_ONE - ((36'(yy_reg) + 36'(zz_reg)) <<< 1);
        raw[1] = (36'(xy_reg) - 36'(wz_reg)) <<< 1;
        raw[2] = (36'(xz_reg) + 36'(wy_reg)) <<< 1;
        raw[3] = (36'(xy_reg) + 36'(wz_reg)) <<< 1;
        raw[4] = ppp_pkg::Q28_ONE - ((36'(xx_reg) + 36'(zz_reg)) <<< 1);
        raw[5] = (36'(yz_reg) - 36'(wx_reg)) <<< 1;
        raw[6] = (36'(xz_reg) - 36'(wy_reg)) <<< 1;
        raw[7] = (36'(yz_reg) + 36'(wx_reg)) <<< 1;
        raw[8] = ppp_pkg::Q28_ONE - ((36'(xx_reg) + 36'(yy_reg)) <<< 1);
        for (int k = 0; k < 9; k++) begin
            rsum[k]   = raw[k] + 36'sd128;
            r_next[k] = rsum[k][35:8];
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < 9; k++) begin
            r_reg[k] <= r_next[k];
        end
        zero_b_reg <= zero_a_reg;
        far_b_reg  <= far_a_reg;
        den_reg    <= ppp_pkg::DENW'(far_a_reg) * ppp_pkg::DENW'(20)
                      - ppp_pkg::DENW'(262144);
    end

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            cfg_o.r[k] = r_reg[k];
        end
        cfg_o.zero_q = zero_b_reg;
        cfg_o.far18  = far_b_reg;
        cfg_o.den    = den_reg;
        cfg_o.cpx    = cam_x_reg;
        cfg_o.cpy    = cam_y_reg;
        cfg_o.cpz    = cam_z_reg;
    end

endmodule

// File: rtl/core/ppp_div.sv
module ppp_div (
    input  logic                       aclk,
    input  logic                       ce,
    input  logic [ppp_pkg::DIV_W-1:0]  num_i,
    input  logic [ppp_pkg::DIV_W-1:0]  den_i,
    output logic [ppp_pkg::DIV_Q-1:0]  quo_o
);

    // restoring divider, one quotient bit per stage, MSB first
    logic [ppp_pkg::DIV_W-1:0] rem_reg [ppp_pkg::DIV_Q];
    logic [ppp_pkg::DIV_W-1:0] dvs_reg [ppp_pkg::DIV_Q];
    logic [ppp_pkg::DIV_Q-1:0] quo_reg [ppp_pkg::DIV_Q];

    for (genvar k = 0; k < ppp_pkg::DIV_Q; k++) begin : g_stage
        localparam int B = ppp_pkg::DIV_Q - 1 - k;
        logic [ppp_pkg::DIV_W-1:0] rem_in, dvs_in, trial, rem_next;
        logic [ppp_pkg::DIV_Q-1:0] quo_in, quo_next;

        if (k == 0) begin : g_first
            assign rem_in = num_i;
            assign dvs_in = den_i;
            assign quo_in = '0;
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign dvs_in = dvs_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        always_comb begin
            trial = dvs_in << B;
            if (rem_in >= trial) begin
                rem_next = rem_in - trial;
                quo_next = quo_in | (ppp_pkg::DIV_Q'(1) << B);
            end else begin
                rem_next = rem_in;
                quo_next = quo_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[k] <= rem_next;
                dvs_reg[k] <= dvs_in;
                quo_reg[k] <= quo_next;
            end
        end
    end

    assign quo_o = quo_reg[ppp_pkg::DIV_Q-1];

endmodule

// File: rtl/core/pinhole_point_projector.sv
// Pinhole point projector.
// Input stream s_*: one map point per request (x, y, z in Q16.16 metres in
// s_tdata, tracked flag in s_tuser). Output stream m_*: one result per
// point: pixel u/v, depth, normalized depth and depth factor in m_tdata,
// visible and tracked flags in m_tuser. Not visible points carry zeros in m_tdata.
// Configuration: cfg_valid/cfg_index/cfg_data write camera position,
// quaternion and max range; cfg_ready is always high. Write only while the
// stream is empty; the derived matrix and far plane settle through stages A and B
// of ppp_cfg after a write, so s_tready is held low by cfg_busy_reg after each write.
// Pipeline: 5 register stages of transform and bounds logic (the first loads at
// the accept edge), 16 stages of bit-per-stage restoring dividers (pixel and
// depth ratios), 1 output register.
// Throughput: one point per cycle, except just after a cfg write. The whole pipe
// advances whenever the output register is empty or being taken; a stalled m_tready
// holds every stage and drops s_tready, nothing is lost or repeated.
// Reset (aresetn low, synchronous) empties the pipe and restores the
// register defaults: camera at origin, identity quaternion, 5 m far plane.
module pinhole_point_projector #(
    parameter int IMG_WIDTH  = ppp_pkg::IMG_WIDTH_DEF,
    parameter int IMG_HEIGHT = ppp_pkg::IMG_HEIGHT_DEF,
    localparam int UW  = $clog2(IMG_WIDTH + 1),
    localparam int VW  = $clog2(IMG_HEIGHT + 1),
    localparam int TDW = ((UW + VW + 63 + 7) / 8) * 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [2:0]      cfg_index,
    input  logic [31:0]     cfg_data,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [95:0]     s_tdata,   // point_x, point_y, point_z
    input  logic            s_tuser,   // tracked_in
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [TDW-1:0]  m_tdata,   // pixel_u, pixel_v, depth, depth_norm, depth_factor
    output logic [1:0]      m_tuser    // visible, tracked_out
);

    localparam int NST = 5;
    localparam logic signed [47:0] W48 = 48'(IMG_WIDTH);
    localparam logic signed [47:0] H48 = 48'(IMG_HEIGHT);

    typedef struct packed {
        logic        vis;
        logic        tr;
        logic [30:0] cz;
    } side_t;

    ppp_pkg::cfg_t cfg;

    ppp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_o     (cfg)
    );

    assign cfg_ready = 1'b1;

    // matrix is not yet settled right after a write
    logic cfg_busy_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_busy_reg <= 1'b0;
        end else begin
            cfg_busy_reg <= cfg_valid && cfg_ready;
        end
    end

    logic ce;
    logic m_tvalid_reg;
    assign ce       = !m_tvalid_reg || m_tready;
    assign s_tready = ce && !cfg_busy_reg;

    logic [NST-1:0] vld_reg;
    logic [NST-2:0] tr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[NST-2:0], s_tvalid && s_tready};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            tr_reg <= {tr_reg[NST-3:0], s_tuser};
        end
    end

    // P1: offset from camera
    logic signed [ppp_pkg::RELW-1:0] rel_reg [3];
    always_ff @(posedge aclk) begin
        if (ce) begin
            rel_reg[0] <= 33'($signed(s_tdata[31:0]))  - 33'($signed(cfg.cpx));
            rel_reg[1] <= 33'($signed(s_tdata[63:32])) - 33'($signed(cfg.cpy));
            rel_reg[2] <= 33'($signed(s_tdata[95:64])) - 33'($signed(cfg.cpz));
        end
    end

    // P2: products, prod[i*3+j] = r[j][i] * rel[j]
    logic signed [ppp_pkg::PRODW-1:0] prod_next [9];
    logic signed [ppp_pkg::PRODW-1:0] prod_reg [9];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                prod_next[i*3+j] = $signed(cfg.r[j*3+i]) * rel_reg[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < 9; k++) begin
                prod_reg[k] <= prod_next[k];
            end
        end
    end

    // P3: sums rounded to Q16.16
    logic signed [ppp_pkg::SUMW-1:0] sum [3];
    logic signed [ppp_pkg::CAMW-1:0] cam_reg [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sum[i] = 64'(prod_reg[i*3]) + 64'(prod_reg[i*3+1]) + 64'(prod_reg[i*3+2])
                     + 64'sd524288;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                cam_reg[i] <= sum[i][63:20];
            end
        end
    end

    // P4: range, near-plane and zero-quaternion check
    logic        ovf4;
    logic        near4;
    logic signed [36:0] cz20;
    logic        ok4_reg;
    logic signed [31:0] cx_reg, cy_reg, cz_reg;

    always_comb begin
        ovf4 = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (!((&cam_reg[i][43:31]) || !(|cam_reg[i][43:31]))) begin
                ovf4 = 1'b1;
            end
        end
        cz20  = 37'($signed(cam_reg[2][31:0])) * 37'sd20;
        near4 = cz20 <= ppp_pkg::NEAR_ONE;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            ok4_reg <= !ovf4 && !near4 && !cfg.zero_q;
            cx_reg  <= cam_reg[0][31:0];
            cy_reg  <= cam_reg[1][31:0];
            cz_reg  <= cam_reg[2][31:0];
        end
    end

    // P5: image bounds, depth ratio terms, divider operands
    logic signed [47:0] nu, nv, lim_u, lim_v;
    logic               in_img;
    logic [ppp_pkg::FARW-1:0] cd18;
    logic signed [42:0] num;
    logic [ppp_pkg::DENW-1:0] numc;
    side_t side5_reg;
    logic [ppp_pkg::DIV_W-1:0] u_n_reg, v_n_reg, uv_d_reg, dn_n_reg, dn_d_reg;

    always_comb begin
        nu     = W48 * (48'(cx_reg) + 48'(cz_reg));
        nv     = W48 * 48'(cy_reg) + H48 * 48'(cz_reg);
        lim_u  = (W48 <<< 1) * 48'(cz_reg);
        lim_v  = (H48 <<< 1) * 48'(cz_reg);
        in_img = (nu >= 48'sd0) && (nu < lim_u) && (nv >= 48'sd0) && (nv < lim_v);
        cd18   = ppp_pkg::FARW'(cz_reg) << 2;
        if (cd18 > cfg.far18) begin
            cd18 = cfg.far18;
        end
        num = 43'(cd18) * 43'sd20 - 43'sd262144;
        if (num < 43'sd0) begin
            numc = '0;
        end else if (num > 43'(cfg.den)) begin
            numc = cfg.den;
        end else begin
            numc = num[ppp_pkg::DENW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            side5_reg.vis <= ok4_reg && in_img;
            side5_reg.tr  <= tr_reg[NST-2];
            side5_reg.cz  <= cz_reg[30:0];
            u_n_reg       <= ppp_pkg::DIV_W'(nu + 48'(cz_reg));
            v_n_reg       <= ppp_pkg::DIV_W'(nv + 48'(cz_reg));
            uv_d_reg      <= ppp_pkg::DIV_W'(cz_reg[30:0]) << 1;
            dn_n_reg      <= (ppp_pkg::DIV_W'(numc) << 16) + ppp_pkg::DIV_W'(cfg.den);
            dn_d_reg      <= ppp_pkg::DIV_W'(cfg.den) << 1;
        end
    end

    // dividers
    logic [ppp_pkg::DIV_Q-1:0] q_u, q_v, q_dn;

    ppp_div u_div_u (
        .aclk (aclk), .ce (ce), .num_i (u_n_reg), .den_i (uv_d_reg), .quo_o (q_u)
    );

    ppp_div u_div_v (
        .aclk (aclk), .ce (ce), .num_i (v_n_reg), .den_i (uv_d_reg), .quo_o (q_v)
    );

    ppp_div u_div_dn (
        .aclk (aclk), .ce (ce), .num_i (dn_n_reg), .den_i (dn_d_reg), .quo_o (q_dn)
    );

    logic  [ppp_pkg::DIV_Q-1:0] dvld_reg;
    side_t dside_reg [ppp_pkg::DIV_Q];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dvld_reg <= '0;
        end else if (ce) begin
            dvld_reg <= {dvld_reg[ppp_pkg::DIV_Q-2:0], vld_reg[NST-1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            dside_reg[0] <= side5_reg;
            for (int k = 1; k < ppp_pkg::DIV_Q; k++) begin
                dside_reg[k] <= dside_reg[k-1];
            end
        end
    end

    // output register
    side_t      sd;
    logic [16:0] df;
    logic [TDW-1:0] m_tdata_next;
    logic [TDW-1:0] m_tdata_reg;
    logic [1:0]     m_tuser_reg;

    always_comb begin
        sd = dside_reg[ppp_pkg::DIV_Q-1];
        df = ppp_pkg::NORM_ONE - 17'(q_dn);
        if (df < ppp_pkg::DF_MIN) begin
            df = ppp_pkg::DF_MIN;
        end
        m_tdata_next = '0;
        if (sd.vis) begin
            m_tdata_next = TDW'({df[15:0], q_dn, sd.cz, q_v[VW-1:0], q_u[UW-1:0]});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ce) begin
            m_tvalid_reg <= dvld_reg[ppp_pkg::DIV_Q-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= {sd.tr, sd.vis};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: bench/projection_checker.sv
`timescale 1ns / 100ps

module projection_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [95:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [87:0] m_tdata,
    input  logic [1:0]  m_tuser,
    output int          fail_count,
    output int          pending_count,
    output int          result_count,
    output int          visible_count
);

    typedef struct packed {
        logic        visible;
        logic [9:0]  pixel_u;
        logic [8:0]  pixel_v;
        logic [30:0] depth;
        logic [15:0] depth_norm;
        logic [15:0] depth_factor;
        logic        tracked;
    } projection_t;

    projection_t expected_q[$];
    longint cam_x, cam_y, cam_z, qw, qx, qy, qz, range_q16;

    function automatic longint round_shift(longint v, int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic projection_t project_point(logic [95:0] pt, logic trk);
        projection_t res;
        longint rel[3];
        longint rot[3][3];
        longint cam[3];
        longint one, sum, nu, nv, far18, cd18, num, den, dn, df;
        res = '0;
        res.tracked = trk;
        one = longint'(1) << 28;
        rel[0] = longint'($signed(pt[31:0])) - cam_x;
        rel[1] = longint'($signed(pt[63:32])) - cam_y;
        rel[2] = longint'($signed(pt[95:64])) - cam_z;
        if (qw == 0 && qx == 0 && qy == 0 && qz == 0)
            return res;
        rot[0][0] = one - 2 * (qy * qy + qz * qz);
        rot[0][1] = 2 * (qx * qy - qw * qz);
        rot[0][2] = 2 * (qx * qz + qw * qy);
        rot[1][0] = 2 * (qx * qy + qw * qz);
        rot[1][1] = one - 2 * (qx * qx + qz * qz);
        rot[1][2] = 2 * (qy * qz - qw * qx);
        rot[2][0] = 2 * (qx * qz - qw * qy);
        rot[2][1] = 2 * (qy * qz + qw * qx);
        rot[2][2] = one - 2 * (qx * qx + qy * qy);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                rot[i][j] = round_shift(rot[i][j], 8);
        // transposed matrix = conjugate rotation
        for (int i = 0; i < 3; i++) begin
            sum = rot[0][i] * rel[0] + rot[1][i] * rel[1] + rot[2][i] * rel[2];
            cam[i] = round_shift(sum, 20);
            if (cam[i] > 64'sd2147483647 || cam[i] < -64'sd2147483648)
                return res;
        end
        if (cam[2] * 20 <= 65536)
            return res;
        nu = 640 * (cam[0] + cam[2]);
        nv = 640 * cam[1] + 480 * cam[2];
        if (nu < 0 || nu >= 1280 * cam[2] || nv < 0 || nv >= 960 * cam[2])
            return res;
        far18 = (range_q16 > 0) ? range_q16 * 5 : (longint'(5) << 18);
        if (far18 < 13369)
            far18 = 13369;
        cd18 = cam[2] * 4;
        if (cd18 > far18)
            cd18 = far18;
        num = 20 * cd18 - (longint'(1) << 18);
        den = 20 * far18 - (longint'(1) << 18);
        if (num < 0)
            num = 0;
        if (num > den)
            num = den;
        dn = (num * 65536 + den) / (2 * den);
        df = 32768 - dn;
        if (df < 3277)
            df = 3277;
        res.visible = 1'b1;
        res.pixel_u = 10'((nu + cam[2]) / (2 * cam[2]));
        res.pixel_v = 9'((nv + cam[2]) / (2 * cam[2]));
        res.depth = 31'(cam[2]);
        res.depth_norm = 16'(dn);
        res.depth_factor = 16'(df);
        return res;
    endfunction

    always @(posedge aclk) begin
        projection_t got, want;
        if (!aresetn) begin
            cam_x = 0; cam_y = 0; cam_z = 0;
            qw = 16384; qx = 0; qy = 0; qz = 0;
            range_q16 = 0;
            expected_q.delete();
            fail_count = 0;
            result_count = 0;
            visible_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.pixel_u = m_tdata[9:0];
                got.pixel_v = m_tdata[18:10];
                got.depth = m_tdata[49:19];
                got.depth_norm = m_tdata[65:50];
                got.depth_factor = m_tdata[81:66];
                got.visible = m_tuser[0];
                got.tracked = m_tuser[1];
                result_count++;
                if (expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result %h / %b", m_tdata, m_tuser);
                end else begin
                    want = expected_q.pop_front();
                    if (want.visible)
                        visible_count++;
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("mismatch #%0d: exp vis=%b u=%0d v=%0d d=%0d %s",
                                result_count, want.visible, want.pixel_u, want.pixel_v,
                                want.depth, $sformatf("dn=%0d df=%0d trk=%b",
                                want.depth_norm, want.depth_factor, want.tracked));
                            $display("    got vis=%b u=%0d v=%0d d=%0d dn=%0d df=%0d trk=%b",
                                got.visible, got.pixel_u, got.pixel_v, got.depth,
                                got.depth_norm, got.depth_factor, got.tracked);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_q = {expected_q, project_point(s_tdata, s_tuser)};
            if (cfg_valid && cfg_ready) begin
                case (ppp_pkg::reg_idx_t'(cfg_index))
                    ppp_pkg::REG_CAM_X:     cam_x = longint'($signed(cfg_data));
                    ppp_pkg::REG_CAM_Y:     cam_y = longint'($signed(cfg_data));
                    ppp_pkg::REG_CAM_Z:     cam_z = longint'($signed(cfg_data));
                    ppp_pkg::REG_QUAT_W:    qw = longint'($signed(cfg_data[15:0]));
                    ppp_pkg::REG_QUAT_X:    qx = longint'($signed(cfg_data[15:0]));
                    ppp_pkg::REG_QUAT_Y:    qy = longint'($signed(cfg_data[15:0]));
                    ppp_pkg::REG_QUAT_Z:    qz = longint'($signed(cfg_data[15:0]));
                    ppp_pkg::REG_MAX_RANGE: range_q16 = longint'($signed(cfg_data));
                    default: ;
                endcase
            end
        end
        pending_count = expected_q.size();
    end
endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps

module tb;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic [1:0]  m_tuser;
    int          fail_count, pending_count, result_count, visible_count;
    int          idle_cycles;
    int          sent_points;
    bit          out_stalls_on;

    always #6 aclk = ~aclk;

    pinhole_point_projector DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    projection_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending_count(pending_count),
        .result_count(result_count), .visible_count(visible_count)
    );

    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver backpressure, with stall-free stretches
    always @(negedge aclk) begin
        if (!out_stalls_on)
            m_tready <= 1'b1;
        else
            m_tready <= (gap_length() == 0) || ($urandom_range(0, 2) == 0);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready) || (pending_count == 0 && !s_tvalid))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("[pinhole_point_projector] ERROR");
            $finish;
        end
    end

    task automatic write_reg(ppp_pkg::reg_idx_t idx, logic [31:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz, logic trk,
                              bit with_gap);
        int gap;
        gap = with_gap ? gap_length() : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= {pz, py, px};
        s_tuser <= trk;
        do @(posedge aclk); while (!s_tready);
        sent_points++;
    endtask

    task automatic drain_pipe();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_count != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic load_pose(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                             logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z,
                             logic [31:0] range);
        write_reg(ppp_pkg::REG_CAM_X, cx);
        write_reg(ppp_pkg::REG_CAM_Y, cy);
        write_reg(ppp_pkg::REG_CAM_Z, cz);
        write_reg(ppp_pkg::REG_QUAT_W, {16'b0, w});
        write_reg(ppp_pkg::REG_QUAT_X, {16'b0, x});
        write_reg(ppp_pkg::REG_QUAT_Y, {16'b0, y});
        write_reg(ppp_pkg::REG_QUAT_Z, {16'b0, z});
        write_reg(ppp_pkg::REG_MAX_RANGE, range);
        repeat (5) @(posedge aclk);
    endtask

    // mostly points inside the view frustum at depth 0.03..12 m
    task automatic send_scene_point(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
        int depth, lat_x, lat_y;
        depth = $urandom_range(2000, 800000);
        lat_x = $signed($urandom_range(0, 2 * depth)) - depth;
        lat_y = ($signed($urandom_range(0, 2 * depth)) - depth) * 3 / 4;
        case ($urandom_range(0, 9))
            0: send_point($urandom(), $urandom(), $urandom(), 1'($urandom_range(0, 1)), 1'b1);
            1: send_point(cx + lat_x, cy + lat_y, cz - depth, 1'($urandom_range(0, 1)), 1'b1);
            default: send_point(cx + lat_x, cy + lat_y, cz + depth,
                                1'($urandom_range(0, 1)), 1'b1);
        endcase
    endtask

    initial begin
        out_stalls_on = 1'b0;
        sent_points = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: identity pose at reset defaults
        send_point(32'h0, 32'h0, 32'h0001_0000, 1'b1, 1'b0);        // centre
        send_point(32'h0, 32'h0, 32'd3276, 1'b0, 1'b0);             // just at near plane
        send_point(32'h0, 32'h0, 32'd3277, 1'b1, 1'b0);             // just past near plane
        send_point(32'hFFFF_0000, 32'h0, 32'h0001_0000, 1'b1, 1'b0); // left edge
        send_point(32'h0000_FFF0, 32'h0, 32'h0001_0000, 1'b0, 1'b0); // right border rounds up
        send_point(32'h0001_0000, 32'h0, 32'h0001_0000, 1'b1, 1'b0); // right edge, out
        send_point(32'h0, 32'hFFFF_4000, 32'h0001_0000, 1'b1, 1'b0); // top edge
        send_point(32'h0, 32'h0000_BFF8, 32'h0001_0000, 1'b0, 1'b0); // bottom border
        send_point(32'h0, 32'h0, 32'h0064_0000, 1'b1, 1'b0);        // beyond far plane
        send_point(32'h0, 32'h0, 32'hFFFF_0000, 1'b1, 1'b0);        // behind
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0);
        drain_pipe();

        // camera far from the first point, whose camera coordinates are out of range; the second lies near the camera
        load_pose(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'sd16384, 16'd0, 16'd0,
                  16'd0, 32'h7FFF_FFFF);
        send_point(32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 1'b1, 1'b0);
        send_point(32'h8000_1000, 32'h8000_0000, 32'h8000_8000, 1'b0, 1'b0);
        drain_pipe();
        // zero quaternion, then negative and tiny ranges
        load_pose('0, '0, '0, '0, '0, '0, '0, 32'h8000_0000);
        send_point(32'h0, 32'h0, 32'h0001_0000, 1'b1, 1'b0);
        drain_pipe();
        load_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hC000, 16'h4000,
                  16'hC000, 16'h4000, 32'd1);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_0000, 1'b1, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0);
        drain_pipe();

        // random phases with various poses
        out_stalls_on = 1'b1;
        for (int phase = 0; phase < 8; phase++) begin
            logic [31:0] cx, cy, cz, range;
            logic [15:0] w, x, y, z;
            cx = $signed($urandom_range(0, 2000000)) - 1000000;
            cy = $signed($urandom_range(0, 2000000)) - 1000000;
            cz = $signed($urandom_range(0, 2000000)) - 1000000;
            case (phase % 4)
                0: begin w = 16'sd16384; x = '0; y = '0; z = '0; end
                1: begin w = 16'sd11585; x = '0; y = '0; z = 16'sd11585; end
                2: begin w = 16'sd8192; x = 16'sd8192; y = 16'sd8192; z = 16'sd8192; end
                default: begin
                    w = 16'($urandom()); x = 16'($urandom());
                    y = 16'($urandom()); z = 16'($urandom());
                end
            endcase
            range = (phase == 5) ? 32'h7FFF_FFFF : $urandom_range(0, 1000000);
            load_pose(cx, cy, cz, w, x, y, z, range);
            out_stalls_on = (phase != 2);
            for (int k = 0; k < 105; k++) begin
                if (w == 16'sd16384 && x == 0)
                    send_scene_point(cx, cy, cz);
                else if ($urandom_range(0, 3) == 0)
                    send_point($urandom(), $urandom(), $urandom(),
                               1'($urandom_range(0, 1)), 1'b1);
                else
                    send_point(cx + $urandom_range(0, 400000) - 200000,
                               cy + $urandom_range(0, 400000) - 200000,
                               cz + $urandom_range(0, 400000) - 200000,
                               1'($urandom_range(0, 1)), 1'b1);
                if (k == 50) begin
                    // hold off until the pipe is empty
                    @(negedge aclk);
                    s_tvalid <= 1'b0;
                    while (pending_count != 0) @(posedge aclk);
                end
            end
            drain_pipe();
        end

        $display("sent %0d points, %0d results checked, %0d visible, over 12 poses",
                 sent_points, result_count, visible_count);
        if (fail_count == 0)
            $display("[pinhole_point_projector] OK");
        else
            $display("[pinhole_point_projector] ERROR");
        $finish;
    end
endmodule
